>>> hdl/bfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_pkg
// shared constants and types for the box frustum cull block
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int ADDR_W        = 6;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic signed [31:0] SAT_MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_MIN32 = 32'sh80000000;

    // one transformed vertex handed from front to back
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cw;
        logic               last;
    } clip_beat_t;

    // wide enough for the sum of three shifted 64-bit products and one entry
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = SAT_MAX32;
        else if (v < -66'sd2147483648)
            r = SAT_MIN32;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hdl/bfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_front
// vertex transform: three multiplies per column over three column passes
// ----------------------------------------------------------------------------
module bfc_front import bfc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [63:0]        mat [NUM_REGS],
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [31:0] vz,
    input  logic               vlast,
    output logic               out_valid,
    input  logic               out_ready,
    output clip_beat_t         out_beat
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [1:0] col_reg;      // 0 = x, 1 = y, 2 = w (matrix column 3)
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic last_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [31:0] t3_reg;
    logic mv_reg;
    logic [1:0] mc_reg;
    logic signed [31:0] cx_reg, cy_reg, cw_reg;

    logic [1:0] mcol;
    logic signed [31:0] m0, m1, m2, m3;
    logic signed [65:0] acc;

    assign mcol = (col_reg == 2'd2) ? 2'd3 : col_reg;

    function automatic logic signed [31:0] ment(input logic [63:0] m [NUM_REGS],
                                                input logic [1:0] r,
                                                input logic [1:0] c);
        logic [63:0] w;
        w = m[{r, c[1]}];
        return c[0] ? w[63:32] : w[31:0];
    endfunction

    assign m0 = ment(mat, 2'd0, mcol);
    assign m1 = ment(mat, 2'd1, mcol);
    assign m2 = ment(mat, 2'd2, mcol);
    assign m3 = ment(mat, 2'd3, mcol);

    // arithmetic shift is floor rounding
    assign acc = 66'(t3_reg) + 66'(p0_reg >>> FRAC_BITS) + 66'(p1_reg >>> FRAC_BITS)
               + 66'(p2_reg >>> FRAC_BITS);

    assign in_ready  = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);
    assign out_beat  = '{cx: cx_reg, cy: cy_reg, cw: cw_reg, last: last_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (in_valid) state_next = F_MUL;
            F_MUL:  if (mv_reg && mc_reg == 2'd2) state_next = F_PUSH;
            F_PUSH: if (out_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= (state_reg == F_MUL) && (col_reg != 2'd3);
            if (state_reg == F_IDLE)
                col_reg <= '0;
            else if (state_reg == F_MUL && col_reg != 2'd3)
                col_reg <= col_reg + 2'd1;
        end
    end

    // multiply stage then sum stage
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vx_reg   <= vx;
            vy_reg   <= vy;
            vz_reg   <= vz;
            last_reg <= vlast;
        end
        p0_reg <= vx_reg * m0;
        p1_reg <= vy_reg * m1;
        p2_reg <= vz_reg * m2;
        t3_reg <= m3;
        mc_reg <= col_reg;
        if (mv_reg)
        begin
            case (mc_reg)
                2'd0:    cx_reg <= sat32(acc);
                2'd1:    cy_reg <= sat32(acc);
                default: cw_reg <= sat32(acc);
            endcase
        end
    end

endmodule

>>> hdl/bfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_queue
// small fifo decoupling the transform from the divide and bounds logic
// ----------------------------------------------------------------------------
module bfc_queue import bfc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  clip_beat_t in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output clip_beat_t out_beat
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    clip_beat_t mem [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_beat  = mem[rp_reg];

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= in_beat;
    end

endmodule

>>> hdl/bfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_back
// restoring divider for x/w and y/w, running bounds and cull decision
// ----------------------------------------------------------------------------
module bfc_back import bfc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  clip_beat_t in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       culled
);

    localparam int NW = 32 + FRAC_BITS;   // dividend width
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_UPD  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic sel_reg;                          // 0 = x, 1 = y
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   den_reg;
    logic          neg_reg, zero_reg, nzero_reg, nneg_reg;
    logic signed [31:0] cy_reg, nx_reg, ny_reg;
    logic signed [31:0] cw_hold;
    logic last_reg;
    logic signed [31:0] maxx_reg, minx_reg, maxy_reg, miny_reg;
    logic cull_reg;

    logic signed [31:0] num_sel;
    logic [31:0] an, ad;
    logic [33:0] trial;
    logic signed [31:0] qres;
    logic signed [31:0] one_p, one_n;
    logic signed [31:0] mxx, mnx, mxy, mny;

    assign one_p = 32'sd1 <<< FRAC_BITS;
    assign one_n = -one_p;

    assign in_ready  = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_OUT);
    assign culled    = cull_reg;

    // x numerator on accept, y numerator on the second divider load
    assign num_sel = (state_reg == B_IDLE) ? in_beat.cx : cy_reg;
    assign an = num_sel[31] ? 32'(-num_sel) : 32'(num_sel);
    assign ad = cw_hold[31] ? 32'(-cw_hold) : 32'(cw_hold);
    assign trial = {rem_reg, quo_reg[NW-1]} - {2'b00, den_reg};

    // signed, saturated quotient
    always_comb
    begin
        if (zero_reg)
            qres = nzero_reg ? 32'sd0 : (nneg_reg ? SAT_MIN32 : SAT_MAX32);
        else if (neg_reg)
            qres = (quo_reg > NW'(33'h080000000)) ? SAT_MIN32 : 32'(-quo_reg);
        else
            qres = (quo_reg > NW'(33'h07fffffff)) ? SAT_MAX32 : quo_reg[31:0];
    end

    // bounds including the current vertex
    assign mxx = (nx_reg > maxx_reg) ? nx_reg : maxx_reg;
    assign mnx = (nx_reg < minx_reg) ? nx_reg : minx_reg;
    assign mxy = (ny_reg > maxy_reg) ? ny_reg : maxy_reg;
    assign mny = (ny_reg < miny_reg) ? ny_reg : miny_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (in_valid) state_next = B_DIV;
            B_DIV:  if (cnt_reg == '0 && sel_reg) state_next = B_UPD;
            B_UPD:  state_next = last_reg ? B_OUT : B_IDLE;
            B_OUT:  if (out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            sel_reg   <= 1'b0;
            cnt_reg   <= '0;
            maxx_reg  <= SAT_MIN32;
            minx_reg  <= SAT_MAX32;
            maxy_reg  <= SAT_MIN32;
            miny_reg  <= SAT_MAX32;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && in_valid)
            begin
                sel_reg <= 1'b0;
                cnt_reg <= CW'(NW);
            end
            else if (state_reg == B_DIV)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else if (!sel_reg)
                begin
                    sel_reg <= 1'b1;
                    cnt_reg <= CW'(NW);
                end
            end
            // update bounds; clear after the last vertex
            if (state_reg == B_UPD)
            begin
                if (last_reg)
                begin
                    maxx_reg <= SAT_MIN32;
                    minx_reg <= SAT_MAX32;
                    maxy_reg <= SAT_MIN32;
                    miny_reg <= SAT_MAX32;
                end
                else
                begin
                    maxx_reg <= mxx;
                    minx_reg <= mnx;
                    maxy_reg <= mxy;
                    miny_reg <= mny;
                end
            end
        end
    end

    // divider datapath, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && in_valid)
        begin
            cy_reg   <= in_beat.cy;
            cw_hold  <= in_beat.cw;
            last_reg <= in_beat.last;
        end
        if ((state_reg == B_IDLE && in_valid) ||
            (state_reg == B_DIV && cnt_reg == '0 && !sel_reg))
        begin
            quo_reg   <= {an, FRAC_BITS'(0)};
            rem_reg   <= '0;
            den_reg   <= state_reg == B_IDLE
                         ? (in_beat.cw[31] ? 32'(-in_beat.cw) : 32'(in_beat.cw)) : ad;
            neg_reg   <= num_sel[31] ^ (state_reg == B_IDLE ? in_beat.cw[31] : cw_hold[31]);
            zero_reg  <= (state_reg == B_IDLE ? in_beat.cw : cw_hold) == '0;
            nzero_reg <= num_sel == '0;
            nneg_reg  <= num_sel[31];
        end
        else if (state_reg == B_DIV && cnt_reg != '0)
        begin
            if (!trial[33])
            begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], quo_reg[NW-1]};
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (state_reg == B_DIV && cnt_reg == '0)
        begin
            if (sel_reg)
                ny_reg <= qres;
            else
                nx_reg <= qres;
        end
        if (state_reg == B_UPD && last_reg)
            cull_reg <= (mxx < one_n) || (mnx > one_p) || (mxy < one_n) || (mny > one_p);
    end

endmodule

>>> hdl/box_frustum_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_frustum_cull
// bounding box cull against the x/y view range after a 4x4 transform
// ----------------------------------------------------------------------------
// Corners stream in one beat each; the beat with tlast closes a box and yields
// one output beat whose tdata bit 0 is culled. The front transform makes three
// column passes per vertex through three 32x32 multipliers; the back end runs a
// one-bit-per-cycle restoring divider twice per vertex, plus an output state on
// a box end, and sets the sustained rate. A 4-entry queue sits between the two.
// Matrix registers are 64-bit APB registers at 8*i and should be written only
// while idle.
module box_frustum_cull import bfc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         s_tlast,   // last_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // culled, zero fill
);

    logic [63:0] mat_reg [NUM_REGS];
    logic [2:0]  ridx;
    logic        cull;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    clip_beat_t  fq_beat, qb_beat;

    assign pready  = 1'b1;
    assign ridx    = paddr[5:3];
    assign prdata  = mat_reg[ridx];
    assign m_tdata = {7'd0, cull};

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'd1 << FRAC_BITS;
            mat_reg[1] <= '0;
            mat_reg[2] <= 64'd1 << (32 + FRAC_BITS);
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= 64'd1 << FRAC_BITS;
            mat_reg[6] <= '0;
            mat_reg[7] <= 64'd1 << (32 + FRAC_BITS);
        end
        else if (psel && penable && pwrite && paddr[2:0] == 3'd0)
            mat_reg[ridx] <= pwdata;
    end

    bfc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .mat(mat_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .vx(s_tdata[31:0]), .vy(s_tdata[63:32]), .vz(s_tdata[95:64]), .vlast(s_tlast),
        .out_valid(fq_valid), .out_ready(fq_ready), .out_beat(fq_beat)
    );

    bfc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_beat(fq_beat),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_beat(qb_beat)
    );

    bfc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qb_valid), .in_ready(qb_ready), .in_beat(qb_beat),
        .out_valid(m_tvalid), .out_ready(m_tready), .culled(cull)
    );

endmodule
